// File: rtl/multi_queue_message_mailbox_core_assert.svh
// assertion macros for the mailbox core and its submodules
// taken in by `include; empty bodies when SYNTHESIS is defined
`ifndef MULTI_QUEUE_MESSAGE_MAILBOX_CORE_ASSERT_SVH
`define MULTI_QUEUE_MESSAGE_MAILBOX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MQMB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox assertion failed");
// next-cycle implication
`define MQMB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox assertion failed");
`else
`define MQMB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define MQMB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mqmb_pkg.sv
// shared types and constants of the message mailbox
// no dependencies
`default_nettype none

package mqmb_pkg;

   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int MSG_MAX_DEF     = 64;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 7;
   localparam logic [COUNT_W-1:0] POS_SAT = 7'd127;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_RECV = 2'd1,
      OP_PEEK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [BYTE_W-1:0]   queue_id;
      logic [BYTE_W-1:0]   msg_len;
      logic [BYTE_W-1:0]   data_byte;
      logic                byte_last;
      logic [BYTE_W-1:0]   recv_capacity;
   } req_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
      logic load_len;
      logic stream;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic recv_go;
      logic want_zero;
      logic stream_end;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/mqmb_ctrl.sv
// mailbox controller: sequences lookup, execute, length fetch and byte stream
// depends on mqmb_pkg and the assertion macro header
`default_nettype none
`include "multi_queue_message_mailbox_core_assert.svh"

module mqmb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   output mqmb_pkg::cmd_type       cmd,
   input  wire mqmb_pkg::stat_type stat
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_LEN    = 5'b01000,
      ST_STREAM = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = stat.recv_go ? ST_LEN : ST_IDLE;
         end
         ST_LEN: begin
            state_in = stat.want_zero ? ST_IDLE : ST_STREAM;
         end
         ST_STREAM: begin
            if (stat.stream_end) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign cmd.capture  = (state_ff == ST_IDLE) && start;
   assign cmd.lookup   = (state_ff == ST_LOOKUP);
   assign cmd.execute  = (state_ff == ST_DECIDE);
   assign cmd.load_len = (state_ff == ST_LEN);
   assign cmd.stream   = (state_ff == ST_STREAM);

   `MQMB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MQMB_ASSERT_NEXT(a_len_exit, clock, reset, (state_ff == ST_LEN) && stat.want_zero, !busy)
   `MQMB_ASSERT_IMPLIES(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))

endmodule

`default_nettype wire

// File: rtl/mqmb_dpath.sv
// mailbox datapath: request latch, queue state store, length and byte stores
// depends on mqmb_pkg and the assertion macro header
`default_nettype none
`include "multi_queue_message_mailbox_core_assert.svh"

module mqmb_dpath #(
   parameter int NUM_QUEUES  = mqmb_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqmb_pkg::QUEUE_DEPTH_DEF,
   parameter int MSG_MAX     = mqmb_pkg::MSG_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mqmb_pkg::cmd_type     cmd,
   output mqmb_pkg::stat_type         stat,
   input  wire logic [1:0]            req_operation,
   input  wire logic [7:0]            req_queue_id,
   input  wire logic [7:0]            req_msg_len,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_byte_last,
   input  wire logic [7:0]            req_recv_capacity,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [6:0]                 rsp_byte_count,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_out_byte_valid,
   output logic                       rsp_result_last
);

   localparam int QW      = $clog2(NUM_QUEUES);
   localparam int SW      = $clog2(QUEUE_DEPTH);
   localparam int FW      = $clog2(QUEUE_DEPTH + 1);
   localparam int PW      = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
   localparam int SLOT_W  = QW + SW;
   localparam int BADDR_W = SLOT_W + PW;
   localparam int QSLOTS  = 1 << QW;
   localparam int SLOTS   = 1 << SLOT_W;
   localparam int BYTES   = 1 << BADDR_W;
   localparam int CW      = mqmb_pkg::COUNT_W;

   // request latch
   mqmb_pkg::req_type req_ff, req_in;

   // send in progress
   logic [CW-1:0]      send_pos_ff, send_pos_in;
   mqmb_pkg::status_type send_verdict_ff, send_verdict_in;
   logic [7:0]         send_len_ff, send_len_in;
   logic [QW-1:0]      send_queue_ff, send_queue_in;

   // queue state store, one word per queue, valid bit per queue
   logic               q_act_mem  [QSLOTS];
   logic [SW-1:0]      q_ws_mem   [QSLOTS];
   logic [SW-1:0]      q_rs_mem   [QSLOTS];
   logic [FW-1:0]      q_fill_mem [QSLOTS];
   logic [QSLOTS-1:0]  qvalid_ff, qvalid_in;
   logic               q_act_rd_ff;
   logic [SW-1:0]      q_ws_rd_ff, q_rs_rd_ff;
   logic [FW-1:0]      q_fill_rd_ff;
   logic               qv_rd_ff;
   logic [QW-1:0]      cur_q_ff, cur_q_in;

   // message stores
   logic [CW-1:0]      len_mem  [SLOTS];
   logic [7:0]         byte_mem [BYTES];
   logic [CW-1:0]      len_rd_ff;
   logic [7:0]         byte_rd_ff;

   // receive stream
   logic [SLOT_W-1:0]  rd_slot_ff, rd_slot_in;
   logic [CW-1:0]      want_ff, want_in;
   logic [CW-1:0]      idx_ff, idx_in;

   // result register
   logic               rsp_strobe_ff, rsp_strobe_in;
   mqmb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_last_ff, rsp_last_in;

   // decide-cycle signals
   logic               qid_ok;
   logic               is_first;
   logic [QW-1:0]      lk_q;
   logic               cur_active;
   logic [SW-1:0]      cur_ws, cur_rs;
   logic [FW-1:0]      cur_fill;
   logic               need_activate;
   logic [SW-1:0]      b_ws;
   logic [FW-1:0]      b_fill;
   mqmb_pkg::status_type verdict;
   logic [7:0]         send_len;
   logic [CW-1:0]      pos_next;
   logic [CW-1:0]      commit_count;
   logic               recv_bad;

   logic               q_we;
   logic               q_wr_act;
   logic [SW-1:0]      q_wr_ws, q_wr_rs;
   logic [FW-1:0]      q_wr_fill;
   logic               byte_we;
   logic               len_we;
   logic [CW-1:0]      len_cap;
   logic [CW-1:0]      want;

   always_comb begin
      req_in = req_ff;
      if (cmd.capture) begin
         req_in.operation     = mqmb_pkg::op_type'(req_operation);
         req_in.queue_id      = req_queue_id;
         req_in.msg_len       = req_msg_len;
         req_in.data_byte     = req_data_byte;
         req_in.byte_last     = req_byte_last;
         req_in.recv_capacity = req_recv_capacity;
      end
   end

   assign qid_ok   = (req_ff.queue_id < 8'(NUM_QUEUES));
   assign is_first = (send_pos_ff == '0);

   // later bytes of a send follow the queue latched on its first byte
   assign lk_q = ((req_ff.operation == mqmb_pkg::OP_SEND) && !is_first) ?
                 send_queue_ff : req_ff.queue_id[QW-1:0];
   assign cur_q_in = cmd.lookup ? lk_q : cur_q_ff;

   // queue word as seen after reset until first written
   assign cur_active = qv_rd_ff ? q_act_rd_ff : (cur_q_ff == '0) || (cur_q_ff == QW'(1));
   assign cur_ws     = qv_rd_ff ? q_ws_rd_ff : '0;
   assign cur_rs     = qv_rd_ff ? q_rs_rd_ff : '0;
   assign cur_fill   = qv_rd_ff ? q_fill_rd_ff : '0;

   assign need_activate = is_first && qid_ok && !cur_active;
   assign b_ws     = need_activate ? '0 : cur_ws;
   assign b_fill   = need_activate ? '0 : cur_fill;
   assign send_len = is_first ? req_ff.msg_len : send_len_ff;
   assign pos_next = (send_pos_ff == mqmb_pkg::POS_SAT) ? send_pos_ff : send_pos_ff + CW'(1);
   assign commit_count = (send_len < {1'b0, pos_next}) ? send_len[CW-1:0] : pos_next;
   assign recv_bad = !qid_ok || !cur_active;

   always_comb begin
      if (!is_first) begin
         verdict = send_verdict_ff;
      end else if (!qid_ok || (req_ff.msg_len > 8'(MSG_MAX))) begin
         verdict = mqmb_pkg::STATUS_BAD;
      end else if (b_fill >= FW'(QUEUE_DEPTH)) begin
         verdict = mqmb_pkg::STATUS_FULL;
      end else begin
         verdict = mqmb_pkg::STATUS_OK;
      end
   end

   // receive length: stored length cut to the message limit and the capacity
   assign len_cap = (len_rd_ff > CW'(MSG_MAX)) ? CW'(MSG_MAX) : len_rd_ff;
   assign want    = ({1'b0, len_cap} > req_ff.recv_capacity) ?
                    req_ff.recv_capacity[CW-1:0] : len_cap;

   assign stat.recv_go    = cmd.execute && (req_ff.operation == mqmb_pkg::OP_RECV) &&
                            !recv_bad && (cur_fill != '0);
   assign stat.want_zero  = (want == '0);
   assign stat.stream_end = (idx_ff == want_ff - CW'(1));

   always_comb begin
      send_pos_in     = send_pos_ff;
      send_verdict_in = send_verdict_ff;
      send_len_in     = send_len_ff;
      send_queue_in   = send_queue_ff;
      rd_slot_in      = rd_slot_ff;
      want_in         = want_ff;
      idx_in          = idx_ff;
      q_we            = 1'b0;
      q_wr_act        = cur_active;
      q_wr_ws         = b_ws;
      q_wr_rs         = need_activate ? '0 : cur_rs;
      q_wr_fill       = b_fill;
      byte_we         = 1'b0;
      len_we          = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = mqmb_pkg::STATUS_OK;
      rsp_count_in    = '0;
      rsp_bvalid_in   = 1'b0;
      rsp_last_in     = 1'b0;

      if (cmd.execute) begin
         unique case (req_ff.operation)
            mqmb_pkg::OP_SEND: begin
               if (need_activate) begin
                  q_we     = 1'b1;
                  q_wr_act = 1'b1;
               end
               if (is_first) begin
                  send_len_in   = req_ff.msg_len;
                  send_queue_in = req_ff.queue_id[QW-1:0];
               end
               byte_we = (verdict == mqmb_pkg::STATUS_OK) && ({1'b0, send_pos_ff} < send_len);
               if (req_ff.byte_last) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_status_in   = verdict;
                  rsp_last_in     = 1'b1;
                  send_pos_in     = '0;
                  send_verdict_in = mqmb_pkg::STATUS_OK;
                  if (verdict == mqmb_pkg::STATUS_OK) begin
                     rsp_count_in = commit_count;
                     len_we       = 1'b1;
                     q_we         = 1'b1;
                     q_wr_ws      = (b_ws == SW'(QUEUE_DEPTH - 1)) ? '0 : b_ws + SW'(1);
                     q_wr_fill    = b_fill + FW'(1);
                  end
               end else begin
                  send_pos_in     = pos_next;
                  send_verdict_in = verdict;
               end
            end
            mqmb_pkg::OP_RECV: begin
               send_pos_in     = '0;
               send_verdict_in = mqmb_pkg::STATUS_OK;
               rd_slot_in      = {cur_q_ff, cur_rs};
               if (recv_bad) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = mqmb_pkg::STATUS_BAD;
                  rsp_last_in   = 1'b1;
               end else if (cur_fill == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_last_in   = 1'b1;
               end else begin
                  q_we      = 1'b1;
                  q_wr_rs   = (cur_rs == SW'(QUEUE_DEPTH - 1)) ? '0 : cur_rs + SW'(1);
                  q_wr_fill = cur_fill - FW'(1);
               end
            end
            mqmb_pkg::OP_PEEK: begin
               send_pos_in     = '0;
               send_verdict_in = mqmb_pkg::STATUS_OK;
               rsp_strobe_in   = 1'b1;
               rsp_last_in     = 1'b1;
               rsp_count_in    = qid_ok ? CW'(cur_fill) : '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_len) begin
         want_in = want;
         idx_in  = '0;
         if (want == '0) begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
         end
      end

      // one byte read per cycle; the result shows with the read data
      if (cmd.stream) begin
         idx_in        = idx_ff + CW'(1);
         rsp_strobe_in = 1'b1;
         rsp_count_in  = want_ff;
         rsp_bvalid_in = 1'b1;
         rsp_last_in   = stat.stream_end;
      end
   end

   always_comb begin
      qvalid_in = qvalid_ff;
      if (q_we) qvalid_in[cur_q_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_pos_ff     <= '0;
         send_verdict_ff <= mqmb_pkg::STATUS_OK;
         qvalid_ff       <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         send_pos_ff     <= send_pos_in;
         send_verdict_ff <= send_verdict_in;
         qvalid_ff       <= qvalid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      send_len_ff   <= send_len_in;
      send_queue_ff <= send_queue_in;
      cur_q_ff      <= cur_q_in;
      rd_slot_ff    <= rd_slot_in;
      want_ff       <= want_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // queue state store
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_act_mem[cur_q_ff]  <= q_wr_act;
         q_ws_mem[cur_q_ff]   <= q_wr_ws;
         q_rs_mem[cur_q_ff]   <= q_wr_rs;
         q_fill_mem[cur_q_ff] <= q_wr_fill;
      end
      if (cmd.lookup) begin
         q_act_rd_ff  <= q_act_mem[lk_q];
         q_ws_rd_ff   <= q_ws_mem[lk_q];
         q_rs_rd_ff   <= q_rs_mem[lk_q];
         q_fill_rd_ff <= q_fill_mem[lk_q];
         qv_rd_ff     <= qvalid_ff[lk_q];
      end
   end

   // message length store
   always_ff @(posedge clock) begin
      if (len_we) len_mem[{cur_q_ff, b_ws}] <= commit_count;
      if (cmd.execute) len_rd_ff <= len_mem[{cur_q_ff, cur_rs}];
   end

   // message byte store
   always_ff @(posedge clock) begin
      if (cmd.execute && byte_we) begin
         byte_mem[{cur_q_ff, b_ws, send_pos_ff[PW-1:0]}] <= req_ff.data_byte;
      end
      if (cmd.stream) byte_rd_ff <= byte_mem[{rd_slot_ff, idx_ff[PW-1:0]}];
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_byte_count     = rsp_count_ff;
   assign rsp_out_byte       = rsp_bvalid_ff ? byte_rd_ff : '0;
   assign rsp_out_byte_valid = rsp_bvalid_ff;
   assign rsp_result_last    = rsp_last_ff;

   `MQMB_ASSERT_IMPLIES(a_byte_has_count, clock, reset, rsp_strobe_ff && rsp_bvalid_ff, rsp_count_ff != '0)
   `MQMB_ASSERT_IMPLIES(a_err_no_byte, clock, reset, rsp_strobe_ff && (rsp_status_ff != mqmb_pkg::STATUS_OK), !rsp_bvalid_ff)
   `MQMB_ASSERT_IMPLIES(a_fill_bound, clock, reset, q_we, q_wr_fill <= FW'(QUEUE_DEPTH))
   `MQMB_ASSERT_IMPLIES(a_stream_in_msg, clock, reset, cmd.stream, idx_ff < CW'(MSG_MAX))

endmodule

`default_nettype wire

// File: rtl/multi_queue_message_mailbox_core.sv
// top level of the multi-queue message mailbox
// depends on mqmb_pkg, mqmb_ctrl and mqmb_dpath
//
// An item is taken when start is high and busy is low; busy then stays high
// while the item is worked on. Every item (send byte, peek, ignored code)
// holds busy through the queue state read and the decision, each held in
// a registered state; a new item is taken only after busy falls. A receive
// with bytes to deliver also holds busy for the length fetch and then for
// a stream off the message byte store's single read port. Results appear one
// cycle after the work that makes them, each for a single cycle marked by
// rsp_strobe, and must be taken then: there is no way to hold them off. A
// send gives one status result on its last byte only. No clearing pass runs
// after reset; the block is ready in the first cycle after reset.
`default_nettype none

module multi_queue_message_mailbox_core #(
   parameter int NUM_QUEUES  = mqmb_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = mqmb_pkg::QUEUE_DEPTH_DEF,
   parameter int MSG_MAX     = mqmb_pkg::MSG_MAX_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_queue_id,
   input  wire logic [7:0] req_msg_len,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_byte_last,
   input  wire logic [7:0] req_recv_capacity,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_status,
   output logic [6:0]      rsp_byte_count,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_byte_valid,
   output logic            rsp_result_last
);

   mqmb_pkg::cmd_type  cmd;
   mqmb_pkg::stat_type stat;

   mqmb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   mqmb_dpath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MSG_MAX     (MSG_MAX)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_queue_id       (req_queue_id),
      .req_msg_len        (req_msg_len),
      .req_data_byte      (req_data_byte),
      .req_byte_last      (req_byte_last),
      .req_recv_capacity  (req_recv_capacity),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_byte_valid (rsp_out_byte_valid),
      .rsp_result_last    (rsp_result_last)
   );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for multi_queue_message_mailbox_core
// depends on mqmb_pkg and the mailbox core rtl; keeps its own model of the queues
// directed checks first, then random message traffic under several idle settings
`timescale 1ns / 100ps

module testbench;

   localparam int NQ            = mqmb_pkg::NUM_QUEUES_DEF;
   localparam int QD            = mqmb_pkg::QUEUE_DEPTH_DEF;
   localparam int MM            = mqmb_pkg::MSG_MAX_DEF;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      mqmb_pkg::status_type status;
      logic [6:0]           byte_count;
      logic [7:0]           out_byte;
      logic                 out_valid;
      logic                 last;
   } mbox_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_operation = mqmb_pkg::OP_NONE;
   logic [7:0] req_queue_id = 8'd0;
   logic [7:0] req_msg_len = 8'd0;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_byte_last = 1'b0;
   logic [7:0] req_recv_capacity = 8'd0;
   logic       rsp_strobe;
   logic [1:0] rsp_status;
   logic [6:0] rsp_byte_count;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_byte_valid;
   logic       rsp_result_last;

   // model of the mailbox
   bit                   q_active [NQ];
   int unsigned          q_wr [NQ];
   int unsigned          q_rd [NQ];
   int unsigned          q_fill [NQ];
   int unsigned          slot_len [NQ*QD];
   logic [7:0]           slot_bytes [NQ*QD*MM];
   int unsigned          tx_pos;
   mqmb_pkg::status_type tx_verdict;
   int unsigned          tx_queue;

   mbox_reply_type due_replies [$];

   int unsigned items_sent = 0;
   int unsigned replies_seen = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;

   multi_queue_message_mailbox_core DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_queue_id       (req_queue_id),
      .req_msg_len        (req_msg_len),
      .req_data_byte      (req_data_byte),
      .req_byte_last      (req_byte_last),
      .req_recv_capacity  (req_recv_capacity),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_byte_valid (rsp_out_byte_valid),
      .rsp_result_last    (rsp_result_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  due_replies.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void clear_mailbox();
      int unsigned i;
      for (i = 0; i < NQ; i++) begin
         q_active[i] = (i < 2);
         q_wr[i] = 0;
         q_rd[i] = 0;
         q_fill[i] = 0;
      end
      tx_pos = 0;
      tx_verdict = mqmb_pkg::STATUS_OK;
      tx_queue = 0;
   endfunction

   function automatic void push_reply(mqmb_pkg::status_type st, int unsigned cnt,
                                      logic [7:0] data, logic valid, logic last);
      mbox_reply_type r;
      r.status = st;
      r.byte_count = cnt[6:0];
      r.out_byte = data;
      r.out_valid = valid;
      r.last = last;
      due_replies.push_back(r);
   endfunction

   // updates the model for one accepted transfer and queues the replies it causes
   function automatic void advance_mailbox(mqmb_pkg::op_type op, int unsigned qid,
                                           int unsigned len, logic [7:0] data, logic last,
                                           int unsigned cap);
      int unsigned slot, want, cnt, i;
      case (op)
         mqmb_pkg::OP_SEND: begin
            if (tx_pos == 0) begin
               tx_queue = qid;
               if (qid >= NQ) begin
                  tx_verdict = mqmb_pkg::STATUS_BAD;
               end else begin
                  // an inactive queue is created and emptied even if the send fails
                  if (!q_active[qid]) begin
                     q_active[qid] = 1'b1;
                     q_wr[qid] = 0;
                     q_rd[qid] = 0;
                     q_fill[qid] = 0;
                  end
                  if (len > MM) begin
                     tx_verdict = mqmb_pkg::STATUS_BAD;
                  end else if (q_fill[qid] >= QD) begin
                     tx_verdict = mqmb_pkg::STATUS_FULL;
                  end else begin
                     tx_verdict = mqmb_pkg::STATUS_OK;
                     slot_len[qid*QD + q_wr[qid]] = len;
                  end
               end
            end
            if (tx_verdict == mqmb_pkg::STATUS_OK && tx_queue < NQ) begin
               slot = tx_queue*QD + q_wr[tx_queue];
               if (tx_pos < slot_len[slot] && tx_pos < MM) slot_bytes[slot*MM + tx_pos] = data;
            end
            if (tx_pos < 127) tx_pos++;
            if (last) begin
               cnt = 0;
               if (tx_verdict == mqmb_pkg::STATUS_OK && tx_queue < NQ) begin
                  slot = tx_queue*QD + q_wr[tx_queue];
                  cnt = (slot_len[slot] > tx_pos) ? tx_pos : slot_len[slot];
                  slot_len[slot] = cnt;
                  q_wr[tx_queue] = (q_wr[tx_queue] + 1) % QD;
                  q_fill[tx_queue]++;
               end
               push_reply(tx_verdict, cnt, 8'd0, 1'b0, 1'b1);
               tx_pos = 0;
               tx_verdict = mqmb_pkg::STATUS_OK;
            end
         end
         mqmb_pkg::OP_RECV: begin
            tx_pos = 0;
            tx_verdict = mqmb_pkg::STATUS_OK;
            if (qid >= NQ || !q_active[qid]) begin
               push_reply(mqmb_pkg::STATUS_BAD, 0, 8'd0, 1'b0, 1'b1);
            end else if (q_fill[qid] == 0) begin
               push_reply(mqmb_pkg::STATUS_OK, 0, 8'd0, 1'b0, 1'b1);
            end else begin
               slot = qid*QD + q_rd[qid];
               want = slot_len[slot];
               if (want > MM) want = MM;
               if (want > cap) want = cap;
               q_rd[qid] = (q_rd[qid] + 1) % QD;
               q_fill[qid]--;
               if (want == 0) begin
                  push_reply(mqmb_pkg::STATUS_OK, 0, 8'd0, 1'b0, 1'b1);
               end else begin
                  for (i = 0; i < want; i++)
                     push_reply(mqmb_pkg::STATUS_OK, want, slot_bytes[slot*MM + i], 1'b1,
                                i + 1 == want);
               end
            end
         end
         mqmb_pkg::OP_PEEK: begin
            tx_pos = 0;
            tx_verdict = mqmb_pkg::STATUS_OK;
            push_reply(mqmb_pkg::STATUS_OK, (qid < NQ) ? q_fill[qid] : 0, 8'd0, 1'b0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // one transfer on the request side; start is lowered at the accepting edge
   task automatic apply_item(mqmb_pkg::op_type op, logic [7:0] qid, logic [7:0] len,
                             logic [7:0] data, logic last, logic [7:0] cap);
      int unsigned gap;
      gap = 1;
      if ($urandom_range(0, 99) < sender_idle_pct) gap += $urandom_range(1, 8);
      repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_queue_id <= qid;
      req_msg_len <= len;
      req_data_byte <= data;
      req_byte_last <= last;
      req_recv_capacity <= cap;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      advance_mailbox(op, qid, len, data, last, cap);
      items_sent++;
   endtask

   task automatic send_message(logic [7:0] qid, logic [7:0] len, int unsigned nbytes,
                               bit close, bit vary_len);
      int unsigned k;
      logic [7:0] len_now;
      for (k = 0; k < nbytes; k++) begin
         // only the length on the first byte counts
         len_now = (k != 0 && vary_len) ? 8'($urandom_range(0, 255)) : len;
         apply_item(mqmb_pkg::OP_SEND, qid, len_now, 8'($urandom_range(0, 255)),
                    close && (k + 1 == nbytes), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic receive_from(logic [7:0] qid, logic [7:0] cap);
      apply_item(mqmb_pkg::OP_RECV, qid, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cap);
   endtask

   task automatic peek_at(logic [7:0] qid);
      apply_item(mqmb_pkg::OP_PEEK, qid, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (due_replies.size() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reply side: the block cannot be stalled, so every strobe is checked
   always @(posedge clock) begin
      mbox_reply_type got, want;
      if (!reset && rsp_strobe) begin
         got.status = mqmb_pkg::status_type'(rsp_status);
         got.byte_count = rsp_byte_count;
         got.out_byte = rsp_out_byte;
         got.out_valid = rsp_out_byte_valid;
         got.last = rsp_result_last;
         replies_seen++;
         if (due_replies.size() == 0) begin
            $display("%0t: reply with nothing due: status %0d count %0d byte %0h", $time,
                     got.status, got.byte_count, got.out_byte);
            error_count++;
         end else begin
            want = due_replies.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               error_count++;
            end
            if (got.byte_count !== want.byte_count) begin
               $display("%0t: byte_count expected %0d got %0d", $time, want.byte_count,
                        got.byte_count);
               error_count++;
            end
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %0h got %0h", $time, want.out_byte,
                        got.out_byte);
               error_count++;
            end
            if (got.out_valid !== want.out_valid) begin
               $display("%0t: out_byte_valid expected %0b got %0b", $time, want.out_valid,
                        got.out_valid);
               error_count++;
            end
            if (got.last !== want.last) begin
               $display("%0t: result_last expected %0b got %0b", $time, want.last, got.last);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_state();
      peek_at(8'd0);
      peek_at(8'd200);
      receive_from(8'd5, 8'd255);
      receive_from(8'd255, 8'd255);
      receive_from(8'd0, 8'd255);
      apply_item(mqmb_pkg::OP_NONE, 8'd0, 8'd255, 8'd255, 1'b1, 8'd255);
   endtask

   task automatic test_send_receive();
      // zero-length message, then one cut to nothing by a zero capacity
      apply_item(mqmb_pkg::OP_SEND, 8'd0, 8'd0, 8'hFF, 1'b1, 8'd0);
      receive_from(8'd0, 8'd255);
      apply_item(mqmb_pkg::OP_SEND, 8'd0, 8'd1, 8'h5A, 1'b1, 8'd0);
      receive_from(8'd0, 8'd0);
      apply_item(mqmb_pkg::OP_SEND, 8'd1, 8'd3, 8'hFF, 1'b0, 8'd0);
      apply_item(mqmb_pkg::OP_SEND, 8'd1, 8'd3, 8'h00, 1'b0, 8'd0);
      apply_item(mqmb_pkg::OP_SEND, 8'd1, 8'd3, 8'hA5, 1'b1, 8'd0);
      peek_at(8'd1);
      receive_from(8'd1, 8'd2);
   endtask

   task automatic test_send_errors();
      apply_item(mqmb_pkg::OP_SEND, 8'd0, 8'd65, 8'h11, 1'b1, 8'd0);
      apply_item(mqmb_pkg::OP_SEND, 8'd1, 8'd255, 8'h22, 1'b1, 8'd0);
      apply_item(mqmb_pkg::OP_SEND, 8'd8, 8'd1, 8'h33, 1'b1, 8'd0);
      // failing send still brings queue 7 to life
      apply_item(mqmb_pkg::OP_SEND, 8'd7, 8'd200, 8'h44, 1'b1, 8'd0);
      receive_from(8'd7, 8'd255);
   endtask

   task automatic test_dropped_send();
      send_message(8'd2, 8'd4, 2, 1'b0, 1'b0);
      peek_at(8'd2);
      receive_from(8'd2, 8'd255);
   endtask

   task automatic test_queue_full();
      int unsigned k;
      for (k = 0; k < QD; k++) send_message(8'd3, 8'd1, 1, 1'b1, 1'b0);
      send_message(8'd3, 8'd1, 1, 1'b1, 1'b0);
      peek_at(8'd3);
      receive_from(8'd3, 8'd255);
   endtask

   task automatic test_long_run();
      // a run well past the position ceiling, then the longest message back out
      send_message(8'd4, 8'(MM), 130, 1'b1, 1'b0);
      receive_from(8'd4, 8'd255);
      // a run shorter than its length, with the length changing after the first byte
      send_message(8'd4, 8'(MM), 8, 1'b1, 1'b1);
      receive_from(8'd4, 8'd255);
   endtask

   function automatic logic [7:0] pick_queue();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return 8'($urandom_range(0, 3));
      if (r < 92) return 8'($urandom_range(4, NQ - 1));
      return 8'($urandom_range(NQ, 255));
   endfunction

   function automatic logic [7:0] pick_capacity();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'd255;
      if (r < 70) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 8));
   endfunction

   task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct);
      int unsigned stop_at, r, len, nbytes;
      bit broken;
      sender_idle_pct = idle_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(0, 6);
            else if (r < 88) len = $urandom_range(7, 20);
            else if (r < 92) len = MM;
            else len = $urandom_range(MM + 1, 255);
            nbytes = (len == 0) ? 1 : (len > MM) ? $urandom_range(1, 3) : len;
            broken = ($urandom_range(0, 99) < 15);
            if (broken) nbytes = $urandom_range(1, nbytes + 3);
            // a few runs are left open, to be dropped by the next receive or peek
            send_message(pick_queue(), 8'(len), nbytes, $urandom_range(0, 99) >= 5,
                         $urandom_range(0, 99) < 20);
         end else if (r < 85) begin
            receive_from(pick_queue(), pick_capacity());
         end else if (r < 97) begin
            peek_at(pick_queue());
         end else begin
            apply_item(mqmb_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      clear_mailbox();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_send_receive();
      test_send_errors();
      test_dropped_send();
      test_queue_full();
      test_long_run();
      wait_drained();

      test_random_traffic(30, 0);
      wait_drained();
      test_random_traffic(30, 69);
      wait_drained();
      test_random_traffic(25, 27);
      wait_drained();

      $display("covered send, receive, peek and ignored codes: %0d transfers in, %0d replies out",
               items_sent, replies_seen);
      $display("random traffic ran with the sender idle 0, 69 and 27 percent of the time");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
